// File: sv/psia_pkg.sv
// Shared types, constants and lane helper functions of the packed SIMD integer ALU.
package psia_pkg;

   localparam int ModeWidth = 5;
   localparam int HalfWidth = 64;
   localparam int DataWidth = 2 * HalfWidth;
   localparam int WordLanes = DataWidth / 16;
   localparam int ByteLanes = DataWidth / 8;

   localparam logic [15:0] SatMinS16 = 16'h8000;  // -32768
   localparam logic [15:0] SatMaxS16 = 16'h7FFF;  // 32767
   localparam logic [15:0] SatMaxU16 = 16'hFFFF;  // 65535
   localparam logic [7:0]  SatMinS8  = 8'h80;     // -128
   localparam logic [7:0]  SatMaxS8  = 8'h7F;     // 127
   localparam logic [7:0]  SatMaxU8  = 8'hFF;     // 255

   typedef enum logic [ModeWidth-1:0] {
      MODE_PSUBW   = 5'd0,
      MODE_PADDW   = 5'd1,
      MODE_PADDUSW = 5'd2,
      MODE_PHADDSW = 5'd3,
      MODE_PHSUBSW = 5'd4,
      MODE_PSUBSW  = 5'd5,
      MODE_PADDSW  = 5'd6,
      MODE_PCMPGTW = 5'd7,
      MODE_PCMPEQW = 5'd8,
      MODE_PAVGW   = 5'd9,
      MODE_PMULHW  = 5'd10,
      MODE_PMULLW  = 5'd11,
      MODE_PSUBSB  = 5'd12,
      MODE_PADDSB  = 5'd13,
      MODE_PADDUSB = 5'd14,
      MODE_PSUBUSB = 5'd15,
      MODE_PSUBB   = 5'd16,
      MODE_PADDB   = 5'd17,
      MODE_POR     = 5'd18,
      MODE_PXOR    = 5'd19,
      MODE_PAND    = 5'd20,
      MODE_PANDN   = 5'd21,
      MODE_PCMPEQB = 5'd22,
      MODE_PCMPGTB = 5'd23,
      MODE_PAVGB   = 5'd24,
      MODE_PABSB   = 5'd25,
      MODE_PMINUB  = 5'd26,
      MODE_PMAXUB  = 5'd27
   } mode_type;

   // A 17-bit signed sum overflowed 16 bits when its top two bits differ.
   function automatic logic [15:0] sat_s16(input logic [16:0] v);
      logic [15:0] r;
      if (v[16] != v[15]) begin
         r = v[16] ? SatMinS16 : SatMaxS16;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [7:0] sat_s8(input logic [8:0] v);
      logic [7:0] r;
      if (v[8] != v[7]) begin
         r = v[8] ? SatMinS8 : SatMaxS8;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// File: sv/psia_alu.sv
// Combinational lane logic: eight word lanes and sixteen byte lanes of the packed ALU.
module psia_alu
   import psia_pkg::*;
(
   input  mode_type               mode,
   input  logic [DataWidth-1:0]   dst,
   input  logic [DataWidth-1:0]   src,
   output logic [DataWidth-1:0]   result
);

   localparam int HalfWordLanes = WordLanes / 2;

   logic [15:0] dw [WordLanes];
   logic [15:0] sw [WordLanes];
   logic [15:0] rw [WordLanes];
   logic [7:0]  db [ByteLanes];
   logic [7:0]  sb [ByteLanes];
   logic [7:0]  rb [ByteLanes];
   logic [DataWidth-1:0] word_result;
   logic [DataWidth-1:0] byte_result;

   always_comb begin
      for (int k = 0; k < WordLanes; k++) begin
         dw[k] = dst[16*k +: 16];
         sw[k] = src[16*k +: 16];
      end
      for (int k = 0; k < ByteLanes; k++) begin
         db[k] = dst[8*k +: 8];
         sb[k] = src[8*k +: 8];
      end
   end

   // Word lanes.
   always_comb begin
      logic [15:0]        x, y, hu, hv;
      logic [16:0]        ssum, sdif, usum, avg, hsum, hdif;
      logic signed [31:0] prod;
      for (int k = 0; k < WordLanes; k++) begin
         x    = dw[k];
         y    = sw[k];
         ssum = {x[15], x} + {y[15], y};
         sdif = {x[15], x} - {y[15], y};
         usum = {1'b0, x} + {1'b0, y};
         avg  = usum + 17'd1;
         prod = 32'($signed(x)) * 32'($signed(y));
         // Horizontal ops pair up words of dst for the low four results, src for the rest.
         if (k < HalfWordLanes) begin
            hu = dw[2 * (k & (HalfWordLanes - 1))];
            hv = dw[2 * (k & (HalfWordLanes - 1)) + 1];
         end else begin
            hu = sw[2 * (k & (HalfWordLanes - 1))];
            hv = sw[2 * (k & (HalfWordLanes - 1)) + 1];
         end
         hsum = {hu[15], hu} + {hv[15], hv};
         hdif = {hu[15], hu} - {hv[15], hv};
         unique case (mode)
            MODE_PSUBW:   rw[k] = sdif[15:0];
            MODE_PADDW:   rw[k] = ssum[15:0];
            MODE_PADDUSW: rw[k] = usum[16] ? SatMaxU16 : usum[15:0];
            MODE_PHADDSW: rw[k] = sat_s16(hsum);
            MODE_PHSUBSW: rw[k] = sat_s16(hdif);
            MODE_PSUBSW:  rw[k] = sat_s16(sdif);
            MODE_PADDSW:  rw[k] = sat_s16(ssum);
            MODE_PCMPGTW: rw[k] = ($signed(x) > $signed(y)) ? SatMaxU16 : 16'h0000;
            MODE_PCMPEQW: rw[k] = (x == y) ? SatMaxU16 : 16'h0000;
            MODE_PAVGW:   rw[k] = avg[16:1];
            MODE_PMULHW:  rw[k] = prod[31:16];
            MODE_PMULLW:  rw[k] = prod[15:0];
            default:      rw[k] = 16'h0000;
         endcase
      end
   end

   // Byte lanes.
   always_comb begin
      logic [7:0] x, y;
      logic [8:0] ssum, sdif, usum, avg;
      for (int k = 0; k < ByteLanes; k++) begin
         x    = db[k];
         y    = sb[k];
         ssum = {x[7], x} + {y[7], y};
         sdif = {x[7], x} - {y[7], y};
         usum = {1'b0, x} + {1'b0, y};
         avg  = usum + 9'd1;
         unique case (mode)
            MODE_PSUBSB:  rb[k] = sat_s8(sdif);
            MODE_PADDSB:  rb[k] = sat_s8(ssum);
            MODE_PADDUSB: rb[k] = usum[8] ? SatMaxU8 : usum[7:0];
            MODE_PSUBUSB: rb[k] = (x > y) ? sdif[7:0] : 8'h00;
            MODE_PSUBB:   rb[k] = sdif[7:0];
            MODE_PADDB:   rb[k] = ssum[7:0];
            MODE_POR:     rb[k] = x | y;
            MODE_PXOR:    rb[k] = x ^ y;
            MODE_PAND:    rb[k] = x & y;
            MODE_PANDN:   rb[k] = ~x & y;
            MODE_PCMPEQB: rb[k] = (x == y) ? SatMaxU8 : 8'h00;
            MODE_PCMPGTB: rb[k] = ($signed(x) > $signed(y)) ? SatMaxU8 : 8'h00;
            MODE_PAVGB:   rb[k] = avg[8:1];
            // Negating -128 wraps back to 0x80, as the instruction does.
            MODE_PABSB:   rb[k] = y[7] ? 8'(~y + 8'd1) : y;
            MODE_PMINUB:  rb[k] = (x < y) ? x : y;
            MODE_PMAXUB:  rb[k] = (x > y) ? x : y;
            default:      rb[k] = 8'h00;
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < WordLanes; k++) begin
         word_result[16*k +: 16] = rw[k];
      end
      for (int k = 0; k < ByteLanes; k++) begin
         byte_result[8*k +: 8] = rb[k];
      end
   end

   // Word lanes give zero outside their codes, so only the unused codes need both zero.
   assign result = (mode <= MODE_PMULLW) ? word_result : byte_result;

endmodule

// File: sv/packed_simd_integer_alu.sv
// Top level of the 128-bit packed SIMD integer ALU: input register, lane logic, result register.
//
//   channel  direction  ports                         contents
//   req      in         req_tvalid/tready/tdata/tuser  tuser: mode; tdata: dst and src halves
//   rsp      out        rsp_tvalid/tready/tdata        tdata: result halves
//
// Every transaction passes through the input register and then the result register before it
// appears on rsp; one transaction per cycle is sustained while rsp does not stall. The
// eight 16x16 signed multipliers of the word lanes set the cycle time.
// Reset (synchronous, active high) empties both registers. When rsp stalls, the result
// register holds and the input register can still take one more transaction.
module packed_simd_integer_alu
   import psia_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [63:0] dst_low_half, [127:64] dst_high_half, [191:128] src_low_half,
   // [255:192] src_high_half
   input  logic [2*DataWidth-1:0] req_tdata,
   // [4:0] mode
   input  logic [ModeWidth-1:0]   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [63:0] result_low_half, [127:64] result_high_half
   output logic [DataWidth-1:0]   rsp_tdata
);

   logic                 s1_valid_ff, s1_valid_in;
   mode_type             s1_mode_ff, s1_mode_in;
   logic [DataWidth-1:0] s1_dst_ff, s1_dst_in;
   logic [DataWidth-1:0] s1_src_ff, s1_src_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic [DataWidth-1:0] alu_result;
   logic                 s1_advance;
   logic                 req_take;

   // The input register moves on when the result register is empty or being drained.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   psia_alu u_alu (
      .mode   (s1_mode_ff),
      .dst    (s1_dst_ff),
      .src    (s1_src_ff),
      .result (alu_result)
   );

   always_comb begin
      s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
      s1_mode_in   = s1_mode_ff;
      s1_dst_in    = s1_dst_ff;
      s1_src_in    = s1_src_ff;
      if (req_take) begin
         s1_mode_in = mode_type'(req_tuser);
         s1_dst_in  = req_tdata[DataWidth-1:0];
         s1_src_in  = req_tdata[2*DataWidth-1:DataWidth];
      end
      rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = s1_advance ? alu_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff  <= s1_mode_in;
      s1_dst_ff   <= s1_dst_in;
      s1_src_ff   <= s1_src_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // An empty input register always takes a new transaction.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input register empty but request not ready");

   // A held transaction in the input register keeps its operands.
   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_dst_ff)
                                        && $stable(s1_src_ff) && $stable(s1_mode_ff)))
      else $error("stalled input register lost its transaction");

   // A transaction leaving the input register lands in the result register.
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_tvalid)
      else $error("advanced transaction did not reach the result register");

   // Bitwise or passes straight through the byte lanes.
   a_por_result: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_mode_ff == MODE_POR) |=>
         (rsp_tdata == ($past(s1_dst_ff) | $past(s1_src_ff))))
      else $error("por result mismatch");

endmodule
